// ----- hw/rtl/lrupr_pkg.sv -----
// Shared types and constants for the LRU page replacement block.
package lrupr_pkg;

    // Configuration register: frame limit
    localparam int CFG_W = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // Width of the page number on the stream ports
    localparam int PORT_PAGE_W = 16;

    // Saturating totals
    localparam int TOTAL_W = 32;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 32'hFFFF_FFFF;

    // Result stream packing, lowest bit first
    localparam int RES_HIT_BIT   = 0;
    localparam int RES_EVICT_BIT = 1;
    localparam int RES_PAGE_LO   = 2;
    localparam int RES_FAULT_LO  = RES_PAGE_LO + PORT_PAGE_W;
    localparam int RES_ACCESS_LO = RES_FAULT_LO + TOTAL_W;
    localparam int RES_USED_W    = RES_ACCESS_LO + TOTAL_W;
    localparam int M_TDATA_W     = ((RES_USED_W + 7) / 8) * 8;
    localparam int S_TDATA_W     = PORT_PAGE_W;

    // Outcome of one lookup in the frame table
    typedef struct packed {
        logic hit;
        logic evict;
    } lookup_t;

endpackage

// ----- hw/rtl/lrupr_frame_table.sv -----
// Fully associative frame table: parallel tag compare, recency ranks and replacement.
module lrupr_frame_table #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [PAGE_BITS-1:0]          page,
    input  logic [lrupr_pkg::CFG_W-1:0]   frames_cfg,
    output lrupr_pkg::lookup_t            lookup,
    output logic [PAGE_BITS-1:0]          ev_page
);

    localparam int AGE_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int CMP_W = (CNT_W > lrupr_pkg::CFG_W) ? CNT_W : lrupr_pkg::CFG_W;

    logic [PAGE_BITS-1:0] tag_reg [FRAMES];
    logic [AGE_W-1:0]     age_reg [FRAMES];
    logic [AGE_W-1:0]     age_next [FRAMES];
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    logic [FRAMES-1:0]    valid;
    logic [FRAMES-1:0]    match;
    logic [FRAMES-1:0]    victim;
    logic [FRAMES-1:0]    slot;
    logic [AGE_W-1:0]     hit_age;
    logic [AGE_W-1:0]     oldest_age;
    logic [PAGE_BITS-1:0] victim_page;
    logic [CMP_W-1:0]     cfg_ext;
    logic [CMP_W-1:0]     limit;
    logic                 hit;
    logic                 evict;

    // Valid frames always form a prefix, so the fill count gives both the
    // valid marks and the next free frame. Ranks of valid frames are a
    // permutation of 0..count-1, so the least recent frame is the one
    // whose rank equals count-1.
    always_comb
    begin
        oldest_age  = AGE_W'(count_reg - CNT_W'(1));
        hit_age     = '0;
        victim_page = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            valid[i]  = CNT_W'(i) < count_reg;
            match[i]  = valid[i] && (tag_reg[i] == page);
            victim[i] = valid[i] && (age_reg[i] == oldest_age);
            hit_age     = hit_age | (match[i] ? age_reg[i] : '0);
            victim_page = victim_page | (victim[i] ? tag_reg[i] : '0);
        end
        hit = |match;
    end

    // Clamp the configured limit into 1..FRAMES and decide on replacement.
    always_comb
    begin
        cfg_ext = CMP_W'(frames_cfg);
        if (cfg_ext == '0)
        begin
            limit = CMP_W'(1);
        end
        else if (cfg_ext > CMP_W'(FRAMES))
        begin
            limit = CMP_W'(FRAMES);
        end
        else
        begin
            limit = cfg_ext;
        end
        evict = !hit && (CMP_W'(count_reg) >= limit);
    end

    // Frame that receives the new page on a miss.
    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            slot[i] = evict ? victim[i] : (CNT_W'(i) == count_reg);
        end
    end

    // Next recency ranks and fill count.
    always_comb
    begin
        count_next = count_reg;
        for (int i = 0; i < FRAMES; i++)
        begin
            age_next[i] = age_reg[i];
            if (hit)
            begin
                if (match[i])
                begin
                    age_next[i] = '0;
                end
                else if (valid[i] && (age_reg[i] < hit_age))
                begin
                    age_next[i] = age_reg[i] + AGE_W'(1);
                end
            end
            else
            begin
                if (slot[i])
                begin
                    age_next[i] = '0;
                end
                else if (valid[i])
                begin
                    age_next[i] = age_reg[i] + AGE_W'(1);
                end
            end
        end
        if (!hit && !evict)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // Ranks and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int i = 0; i < FRAMES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            count_reg <= count_next;
            for (int i = 0; i < FRAMES; i++)
            begin
                age_reg[i] <= age_next[i];
            end
        end
    end

    // Page tags are only read while their frame is valid.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            if (step && !hit && slot[i])
            begin
                tag_reg[i] <= page;
            end
        end
    end

    assign lookup.hit   = hit;
    assign lookup.evict = evict;
    assign ev_page      = evict ? victim_page : '0;

endmodule

// ----- hw/rtl/lrupr_stats.sv -----
// Saturating fault and access totals.
module lrupr_stats (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          miss,
    output logic [lrupr_pkg::TOTAL_W-1:0] fault_total,
    output logic [lrupr_pkg::TOTAL_W-1:0] access_total
);

    logic [lrupr_pkg::TOTAL_W-1:0] fault_reg;
    logic [lrupr_pkg::TOTAL_W-1:0] fault_next;
    logic [lrupr_pkg::TOTAL_W-1:0] access_reg;
    logic [lrupr_pkg::TOTAL_W-1:0] access_next;

    // Totals including the access now being processed.
    always_comb
    begin
        access_next = access_reg;
        fault_next  = fault_reg;
        if (access_reg != lrupr_pkg::TOTAL_MAX)
        begin
            access_next = access_reg + lrupr_pkg::TOTAL_W'(1);
        end
        if (miss && (fault_reg != lrupr_pkg::TOTAL_MAX))
        begin
            fault_next = fault_reg + lrupr_pkg::TOTAL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_reg  <= '0;
            access_reg <= '0;
        end
        else if (step)
        begin
            fault_reg  <= fault_next;
            access_reg <= access_next;
        end
    end

    assign fault_total  = fault_next;
    assign access_total = access_next;

endmodule

// ----- hw/rtl/lru_page_replacement.sv -----
// Top level of the LRU page replacement tracker: stream ports, pipeline registers, config.
// Each page reference passes an input register and a result register. Its
// result is presented from the result register once the input stage has
// moved on into it, and a new reference is taken in every cycle while the
// result side keeps up. The rate is set by the step that compares the page
// against all frame tags at once and updates every recency rank, the fill
// count and the totals in the same cycle. The frame limit on the
// configuration channel is clamped into 1..FRAMES; lowering it while full
// evicts one page per miss. Reset empties all frames and clears both totals.
module lru_page_replacement #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Page references
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] page_number
    input  logic [lrupr_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // Results
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] hit, [1] evicted_valid, [17:2] evicted_page, [49:18] fault_total,
    // [81:50] access_total, [87:82] zero
    output logic [lrupr_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // Frame limit register
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lrupr_pkg::CFG_W-1:0]       cfg_data
);

    localparam int KEEP_W = (PAGE_BITS < lrupr_pkg::PORT_PAGE_W) ?
                            PAGE_BITS : lrupr_pkg::PORT_PAGE_W;

    logic                                 in_valid_reg;
    logic [lrupr_pkg::PORT_PAGE_W-1:0]    in_page_reg;
    logic                                 res_valid_reg;
    logic                                 res_hit_reg;
    logic                                 res_evict_reg;
    logic [lrupr_pkg::PORT_PAGE_W-1:0]    res_page_reg;
    logic [lrupr_pkg::TOTAL_W-1:0]        res_fault_reg;
    logic [lrupr_pkg::TOTAL_W-1:0]        res_access_reg;
    logic [lrupr_pkg::CFG_W-1:0]          frames_cfg_reg;

    logic                                 advance;
    logic [PAGE_BITS-1:0]                 page_tag;
    logic [PAGE_BITS-1:0]                 ev_page;
    lrupr_pkg::lookup_t                   lookup;
    logic [lrupr_pkg::TOTAL_W-1:0]        fault_total;
    logic [lrupr_pkg::TOTAL_W-1:0]        access_total;

    // Handshake: the input stage moves on when the result register is free.
    assign advance       = in_valid_reg && (!res_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    // Only the low PAGE_BITS of the page number take part.
    assign page_tag = PAGE_BITS'(in_page_reg[KEEP_W-1:0]);

    lrupr_frame_table #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_frame_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .page       (page_tag),
        .frames_cfg (frames_cfg_reg),
        .lookup     (lookup),
        .ev_page    (ev_page)
    );

    lrupr_stats u_stats (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .miss         (!lookup.hit),
        .fault_total  (fault_total),
        .access_total (access_total)
    );

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_cfg_reg <= lrupr_pkg::CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            frames_cfg_reg <= cfg_data;
        end
    end

    // Input stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_page_reg <= s_axis_tdata[lrupr_pkg::PORT_PAGE_W-1:0];
        end
    end

    // Result stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result stage payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_hit_reg    <= lookup.hit;
            res_evict_reg  <= lookup.evict;
            res_page_reg   <= lrupr_pkg::PORT_PAGE_W'(ev_page[KEEP_W-1:0]);
            res_fault_reg  <= fault_total;
            res_access_reg <= access_total;
        end
    end

    // Pack the result transaction.
    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = {
        {(lrupr_pkg::M_TDATA_W - lrupr_pkg::RES_USED_W){1'b0}},
        res_access_reg,
        res_fault_reg,
        res_page_reg,
        res_evict_reg,
        res_hit_reg
    };

endmodule
